FILE: rtl/core/lsrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_pkg
// Shared types and constants of the log sector record checker.
// ----------------------------------------------------------------------------
package lsrc_pkg;

  localparam int          LSRC_SECTOR_BYTES = 4096;
  localparam int          HEADER_BYTES      = 16;
  localparam int          POS_W             = 13;
  localparam int          LEN_W             = 12;
  localparam int          PADDR_W           = 4;
  localparam int          PDATA_W           = 64;
  localparam logic [63:0] MAGIC_RESET       = 64'h4F42_434C_4F47_5631;
  localparam logic [11:0] MAX_LEN_RESET     = 12'd4080;
  localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES          = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_BAD_CRC   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] sector_byte;
    logic       sector_start;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic [63:0]      magic;
    logic [LEN_W-1:0] max_len;
  } cfg_t;

endpackage

FILE: rtl/core/lsrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_if
// Valid/ready channels for sector bytes and verdicts.
// ----------------------------------------------------------------------------
interface lsrc_in_if import lsrc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] sector_byte;
  logic       sector_start;

  modport source (output valid, output sector_byte, output sector_start, input ready);
  modport sink   (input valid, input sector_byte, input sector_start, output ready);
endinterface

interface lsrc_out_if import lsrc_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [LEN_W-1:0] payload_length;

  modport source (output valid, output status, output payload_length, input ready);
  modport sink   (input valid, input status, input payload_length, output ready);
endinterface

FILE: rtl/core/lsrc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_cfg_regs
// APB register file: expected magic and payload length limit.
// ----------------------------------------------------------------------------
module lsrc_cfg_regs import lsrc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [63:0]      magic;
  logic [LEN_W-1:0] max_len;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // one register per 8-byte slot
  always_ff @(posedge clk) begin
    if (rst) begin
      magic   <= MAGIC_RESET;
      max_len <= MAX_LEN_RESET;
    end else if (wr) begin
      if (paddr[3]) begin
        max_len <= pwdata[LEN_W-1:0];
      end else begin
        magic <= pwdata;
      end
    end
  end

  assign prdata = paddr[3] ? {{(PDATA_W-LEN_W){1'b0}}, max_len} : magic;

  assign cfg.magic   = magic;
  assign cfg.max_len = max_len;

endmodule

FILE: rtl/core/lsrc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_in_stage
// Input register for sector bytes.
// ----------------------------------------------------------------------------
module lsrc_in_stage import lsrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lsrc_in_if.sink    sector,
  input  logic       advance,
  output stage_t     stage
);

  logic  valid;
  item_t item;

  assign sector.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sector.ready) begin
      valid <= sector.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sector.ready && sector.valid) begin
      item.sector_byte  <= sector.sector_byte;
      item.sector_start <= sector.sector_start;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

FILE: rtl/core/lsrc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_parser
// Header parse, length check, CRC-32 update and verdict register.
// ----------------------------------------------------------------------------
module lsrc_parser import lsrc_pkg::*; #(
  parameter int SECTOR_BYTES = LSRC_SECTOR_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  stage_t     stage,
  output logic       advance,
  lsrc_out_if.source result
);

  localparam int SECT_LIM = SECTOR_BYTES - HEADER_BYTES;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [POS_W-1:0] pos, pos_next, e_pos;
  logic             mm, mm_next, e_mm;
  logic [31:0]      cap_crc, cap_crc_next, e_cap_crc;
  logic [23:0]      cap_len, cap_len_next, e_cap_len;
  logic [31:0]      run_crc, run_crc_next, e_run_crc;
  logic             vg, vg_next, e_vg;

  logic             o_valid;
  status_t          o_status;
  logic [LEN_W-1:0] o_len;

  logic             fire;
  logic             emit;
  status_t          emit_status;
  logic [LEN_W-1:0] emit_len;
  logic [7:0]       b;
  logic [31:0]      full_len;
  logic [LEN_W-1:0] lim;
  logic [31:0]      crc_new;
  logic             mm_new;

  assign advance = !o_valid || result.ready;
  assign fire    = stage.valid && advance;
  assign b       = stage.item.sector_byte;

  assign full_len = {b, cap_len};
  assign lim      = ({20'd0, cfg.max_len} > 32'(SECT_LIM)) ? LEN_W'(SECT_LIM) : cfg.max_len;

  always_comb begin
    if (stage.item.sector_start) begin
      e_pos     = '0;
      e_mm      = 1'b1;
      e_cap_crc = '0;
      e_cap_len = '0;
      e_run_crc = CRC_ONES;
      e_vg      = 1'b0;
    end else begin
      e_pos     = pos;
      e_mm      = mm;
      e_cap_crc = cap_crc;
      e_cap_len = cap_len;
      e_run_crc = run_crc;
      e_vg      = vg;
    end
  end

  assign mm_new  = e_mm && (b == cfg.magic[{e_pos[2:0], 3'b000} +: 8]);
  assign crc_new = crc_byte(e_run_crc, b);

  always_comb begin
    pos_next     = pos;
    mm_next      = mm;
    cap_crc_next = cap_crc;
    cap_len_next = cap_len;
    run_crc_next = run_crc;
    vg_next      = vg;
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_len     = '0;
    if (fire) begin
      mm_next      = e_mm;
      cap_crc_next = e_cap_crc;
      cap_len_next = e_cap_len;
      run_crc_next = e_run_crc;
      vg_next      = e_vg;
      pos_next     = e_pos;
      if (!e_vg) begin
        pos_next = e_pos + 1'b1;
        if (e_pos < POS_W'(8)) begin
          mm_next = mm_new;
          if (e_pos == POS_W'(7) && !mm_new) begin
            emit        = 1'b1;
            emit_status = ST_BAD_MAGIC;
          end
        end else if (e_pos < POS_W'(12)) begin
          cap_crc_next[{e_pos[1:0], 3'b000} +: 8] = b;
        end else if (e_pos < POS_W'(HEADER_BYTES)) begin
          if (e_pos == POS_W'(15)) begin
            if (full_len == '0 || full_len > {20'd0, lim}) begin
              emit        = 1'b1;
              emit_status = ST_BAD_LEN;
            end
          end else begin
            cap_len_next[{e_pos[1:0], 3'b000} +: 8] = b;
          end
        end else begin
          run_crc_next = crc_new;
          if ({1'b0, e_pos} >= (14'(e_cap_len[LEN_W-1:0]) + 14'd15)) begin
            emit = 1'b1;
            if ((crc_new ^ CRC_ONES) == e_cap_crc) begin
              emit_status = ST_OK;
              emit_len    = e_cap_len[LEN_W-1:0];
            end else begin
              emit_status = ST_BAD_CRC;
            end
          end
        end
        if (emit) begin
          vg_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      vg      <= 1'b1;
      mm      <= 1'b1;
      run_crc <= CRC_ONES;
      cap_crc <= '0;
      cap_len <= '0;
      o_valid <= 1'b0;
    end else begin
      pos     <= pos_next;
      vg      <= vg_next;
      mm      <= mm_next;
      run_crc <= run_crc_next;
      cap_crc <= cap_crc_next;
      cap_len <= cap_len_next;
      if (fire && emit) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      o_status <= emit_status;
      o_len    <= emit_len;
    end
  end

  assign result.valid          = o_valid;
  assign result.status         = o_status;
  assign result.payload_length = o_len;

  a_ok_has_len : assert property (@(posedge clk) disable iff (rst)
    o_valid && o_status == ST_OK |-> o_len != '0)
    else $error("valid verdict with zero length");

  a_bad_no_len : assert property (@(posedge clk) disable iff (rst)
    o_valid && o_status != ST_OK |-> o_len == '0)
    else $error("rejected verdict carries a length");

  a_verdict_closes : assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> vg)
    else $error("sector still open after verdict");

  a_idle_holds_pos : assert property (@(posedge clk) disable iff (rst)
    fire && vg && !stage.item.sector_start |=> $stable(pos))
    else $error("position moved after verdict");

endmodule

FILE: rtl/core/log_sector_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_sector_record_checker
// Checks framed log sectors: magic, length and CRC-32 over the payload.
//
//   channel  dir  payload                        accepted when
//   sector   in   sector_byte, sector_start      valid && ready
//   result   out  status, payload_length         valid && ready
//   apb      in   expected_magic @0, max_len @8  psel && penable && pwrite
//
// One byte per cycle sustained while the result is not stalled; a byte is held in
// the input register, and its verdict, if any, is registered in the result register as it leaves.
// The byte-wise CRC update sits between those two registers.
// A stalled result holds the input stage; bytes keep flowing otherwise.
// Reset is synchronous; after reset bytes are ignored until a sector start.
// ----------------------------------------------------------------------------
module log_sector_record_checker import lsrc_pkg::*; #(
  parameter int SECTOR_BYTES = LSRC_SECTOR_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  lsrc_in_if.sink            sector,
  lsrc_out_if.source         result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  lsrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsrc_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .sector  (sector),
    .advance (advance),
    .stage   (stage)
  );

  lsrc_parser #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .stage   (stage),
    .advance (advance),
    .result  (result)
  );

endmodule

FILE: verif/lsrc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_tb_pkg
// Register map and CRC-32 byte step shared by the sector checker bench.
// ----------------------------------------------------------------------------
package lsrc_tb_pkg;
  import lsrc_pkg::*;

  localparam logic [PADDR_W-1:0] REG_MAGIC_ADDR   = 4'h0;
  localparam logic [PADDR_W-1:0] REG_MAX_LEN_ADDR = 4'h8;

  // reflected CRC-32, one byte, no final xor
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: verif/sector_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_verdict_checker
// Watches the sector byte stream and register writes, predicts the verdict
// of every sector and compares it in order against the result channel.
// ----------------------------------------------------------------------------
module sector_verdict_checker
  import lsrc_pkg::*;
  import lsrc_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  lsrc_in_if                 sector,
  lsrc_out_if                result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 fault_count,
  output int                 verdicts_owed,
  output int                 verdicts_seen
);

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] length;
  } verdict_t;

  logic [63:0]      magic_q;
  logic [LEN_W-1:0] max_len_q;
  logic [POS_W-1:0] pos;
  logic             magic_ok;
  logic [31:0]      crc_field;
  logic [31:0]      len_field;
  logic [31:0]      crc_acc;
  logic             decided;
  verdict_t         owed_verdicts[$];

  function automatic bit predict_verdict(input logic [7:0] b, input logic st,
                                         output verdict_t v);
    int p;
    int lim;
    v.status = ST_OK;
    v.length = '0;
    if (st) begin
      pos       = '0;
      magic_ok  = 1'b1;
      crc_field = '0;
      len_field = '0;
      crc_acc   = CRC_ONES;
      decided   = 1'b0;
    end
    if (decided) return 1'b0;
    p   = int'(pos);
    pos = pos + 1'b1;
    if (p < 8) begin
      if (b != magic_q[8*p +: 8]) magic_ok = 1'b0;
      if (p == 7 && !magic_ok) begin
        v.status = ST_BAD_MAGIC;
        decided  = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (p < 12) begin
      crc_field[8*(p-8) +: 8] = b;
      return 1'b0;
    end
    if (p < HEADER_BYTES) begin
      len_field[8*(p-12) +: 8] = b;
      if (p == HEADER_BYTES - 1) begin
        lim = int'(max_len_q);
        if (lim > LSRC_SECTOR_BYTES - HEADER_BYTES) lim = LSRC_SECTOR_BYTES - HEADER_BYTES;
        if (len_field == 0 || len_field > 32'(lim)) begin
          v.status = ST_BAD_LEN;
          decided  = 1'b1;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    crc_acc = crc32_step(crc_acc, b);
    if (32'(p - HEADER_BYTES + 1) >= len_field) begin
      if ((crc_acc ^ CRC_ONES) == crc_field) begin
        v.status = ST_OK;
        v.length = len_field[LEN_W-1:0];
      end else begin
        v.status = ST_BAD_CRC;
      end
      decided = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    verdict_t want;
    if (rst) begin
      magic_q   = MAGIC_RESET;
      max_len_q = MAX_LEN_RESET;
      pos       = '0;
      magic_ok  = 1'b1;
      crc_field = '0;
      len_field = '0;
      crc_acc   = CRC_ONES;
      decided   = 1'b1;
      owed_verdicts.delete();
      fault_count   = 0;
      verdicts_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_MAGIC_ADDR) magic_q = pwdata;
        else if (paddr == REG_MAX_LEN_ADDR) max_len_q = pwdata[LEN_W-1:0];
      end
      if (sector.valid && sector.ready) begin
        if (predict_verdict(sector.sector_byte, sector.sector_start, v)) begin
          owed_verdicts.push_back(v);
        end
      end
      if (result.valid && result.ready) begin
        verdicts_seen++;
        if (owed_verdicts.size() == 0) begin
          $error("verdict with none owed: status %0d, payload_length %0d",
                 result.status, result.payload_length);
          fault_count++;
        end else begin
          want = owed_verdicts.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            fault_count++;
          end
          if (result.payload_length !== want.length) begin
            $error("payload_length: expected %0d, got %0d", want.length,
                   result.payload_length);
            fault_count++;
          end
        end
      end
    end
    verdicts_owed = owed_verdicts.size();
  end

endmodule

FILE: verif/log_sector_record_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_sector_record_checker_tb
// Feeds framed sectors (good, bad magic, bad length, bad CRC, cut short and
// noise) under several register settings and idle/stall mixes; the verdict
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module log_sector_record_checker_tb;
  import lsrc_pkg::*;
  import lsrc_tb_pkg::*;

  typedef enum {
    SEC_GOOD,
    SEC_BAD_MAGIC,
    SEC_BAD_LEN,
    SEC_BAD_CRC,
    SEC_CUT,
    SEC_NOISE
  } sector_kind_t;

  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASE_BYTES     = 60;
  localparam int PHASE_VERDICTS  = 3;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fault_count;
  int verdicts_owed;
  int verdicts_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int sector_bytes;
  int quiet_cycles;

  logic [63:0]      cur_magic;
  logic [LEN_W-1:0] cur_max;

  lsrc_in_if  sector_ch ();
  lsrc_out_if result_ch ();

  log_sector_record_checker uut (
    .clk     (clk),
    .rst     (rst),
    .sector  (sector_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sector_verdict_checker verdict_chk (
    .clk           (clk),
    .rst           (rst),
    .sector        (sector_ch),
    .result        (result_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fault_count   (fault_count),
    .verdicts_owed (verdicts_owed),
    .verdicts_seen (verdicts_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (sector_ch.valid && sector_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int len_cap();
    if (int'(cur_max) > LSRC_SECTOR_BYTES - HEADER_BYTES) return LSRC_SECTOR_BYTES - HEADER_BYTES;
    return int'(cur_max);
  endfunction

  function automatic int pick_len();
    int cap;
    cap = (len_cap() < 1) ? 1 : len_cap();
    if ($urandom_range(19) == 0) return $urandom_range(1, (cap < 300) ? cap : 300);
    return $urandom_range(1, (cap < 24) ? cap : 24);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      sector_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sector_ch.valid        <= 1'b1;
    sector_ch.sector_byte  <= b;
    sector_ch.sector_start <= st;
    @(posedge clk);
    while (!sector_ch.ready) @(posedge clk);
  endtask

  // hold off until every owed verdict is back
  task automatic hold_for_verdicts();
    sector_ch.valid <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
  endtask

  task automatic settle();
    hold_for_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [63:0] magic, input logic [LEN_W-1:0] max_len);
    write_reg(REG_MAGIC_ADDR, magic);
    write_reg(REG_MAX_LEN_ADDR, {{(PDATA_W-LEN_W){1'b0}}, max_len});
    cur_magic = magic;
    cur_max   = max_len;
  endtask

  // detail: bit to flip for bad magic, length flavor for bad length, -1 random
  task automatic send_sector(input sector_kind_t kind, input int pay_bytes, input int detail);
    logic [7:0]  frame[$];
    logic [7:0]  pay[$];
    logic [63:0] m;
    logic [31:0] crc;
    logic [31:0] len_field;
    int          n;
    int          sel;
    if (kind == SEC_NOISE) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'($urandom_range(1)));
      sector_bytes += n;
      return;
    end
    for (int i = 0; i < pay_bytes; i++) pay.push_back(8'($urandom));
    crc = CRC_ONES;
    foreach (pay[i]) crc = crc32_step(crc, pay[i]);
    crc       = crc ^ CRC_ONES;
    m         = cur_magic;
    len_field = 32'(pay_bytes);
    case (kind)
      SEC_BAD_MAGIC: begin
        sel    = (detail >= 0) ? detail : $urandom_range(63);
        m[sel] = ~m[sel];
      end
      SEC_BAD_CRC: crc = crc ^ ($urandom() | 32'd1);
      SEC_BAD_LEN: begin
        sel = (detail >= 0) ? detail : $urandom_range(2);
        case (sel)
          0:       len_field = '0;
          1:       len_field = 32'(len_cap() + 1 + $urandom_range(15));
          default: len_field = $urandom() | 32'h0001_0000;
        endcase
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) frame.push_back(m[8*i +: 8]);
    for (int i = 0; i < 4; i++) frame.push_back(crc[8*i +: 8]);
    for (int i = 0; i < 4; i++) frame.push_back(len_field[8*i +: 8]);
    foreach (pay[i]) frame.push_back(pay[i]);
    n = (kind == SEC_CUT) ? $urandom_range(1, frame.size() - 1) : frame.size();
    for (int i = 0; i < n; i++) send_byte(frame[i], i == 0);
    sector_bytes += n;
    // trailing bytes without a start
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  function automatic sector_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 55) return SEC_GOOD;
    if (r < 65) return SEC_BAD_CRC;
    if (r < 75) return SEC_BAD_MAGIC;
    if (r < 85) return SEC_BAD_LEN;
    if (r < 95) return SEC_CUT;
    return SEC_NOISE;
  endfunction

  initial begin
    int start_bytes;
    int start_verdicts;
    int count;
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    sector_ch.valid        = 1'b0;
    sector_ch.sector_byte  = '0;
    sector_ch.sector_start = 1'b0;
    result_ch.ready        = 1'b0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    sector_bytes           = 0;
    quiet_cycles           = 0;
    cur_magic              = MAGIC_RESET;
    cur_max                = MAX_LEN_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_sector(SEC_GOOD, 1, -1);
    send_sector(SEC_BAD_MAGIC, 1, 0);
    send_sector(SEC_BAD_MAGIC, 1, 63);
    send_sector(SEC_BAD_LEN, 1, 0);
    send_sector(SEC_BAD_LEN, 1, 1);
    send_sector(SEC_BAD_LEN, 1, 2);
    send_sector(SEC_BAD_CRC, 2, -1);
    send_sector(SEC_CUT, 3, -1);
    send_sector(SEC_GOOD, 3, -1);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          // limit above sector room: clamped to the sector size less the header
          configure('1, '1);
          send_sector(SEC_BAD_LEN, 1, 1);
          settle();
          configure('1, 12'd24);
          send_sector(SEC_GOOD, len_cap(), -1);
          send_sector(SEC_BAD_LEN, 1, 1);
        end
        1: begin
          send_idle_pct = 81; recv_stall_pct = 0;
          configure('0, 12'd1);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 81;
          configure({$urandom(), $urandom()}, LEN_W'($urandom_range(2, 4079)));
        end
        3: begin
          send_idle_pct = 38; recv_stall_pct = 38;
          configure(MAGIC_RESET, MAX_LEN_RESET);
        end
        default: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          configure({$urandom(), $urandom()}, '0);
        end
      endcase
      start_bytes    = sector_bytes;
      start_verdicts = verdicts_seen;
      count          = 0;
      while (sector_bytes - start_bytes < PHASE_BYTES ||
             verdicts_seen - start_verdicts < PHASE_VERDICTS) begin
        send_sector(pick_kind(), pick_len(), -1);
        count++;
        if (count == 3) hold_for_verdicts();
      end
    end

    settle();
    if (fault_count == 0 && verdicts_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: log_sector_record_checker.f
rtl/core/lsrc_pkg.sv
rtl/core/lsrc_if.sv
rtl/core/lsrc_cfg_regs.sv
rtl/core/lsrc_in_stage.sv
rtl/core/lsrc_parser.sv
rtl/core/log_sector_record_checker.sv
verif/lsrc_tb_pkg.sv
verif/sector_verdict_checker.sv
verif/log_sector_record_checker_tb.sv
